FILE: hdl/poi_pkg.sv
// Package with payload types, constants and the arctangent table of the odometry integrator.
package poi_pkg;

  localparam int CordicSteps = 16;
  // The arctangent table has 32 entries, so no more than 32 steps are ever run.
  localparam int CordicIters = (CordicSteps < 32) ? CordicSteps : 32;
  localparam int StepW = $clog2(CordicIters + 1);
  localparam logic [31:0] CordicGain = 32'h26DD3B6A;
  localparam logic [29:0] TurnPerRad = 30'd683565276;

  localparam logic [0:0] RegPoseEn = 1'b0;
  localparam logic [0:0] RegOdomEn = 1'b1;

  typedef struct packed {
    logic signed [23:0] forward_speed;
    logic signed [23:0] lateral_speed;
    logic signed [23:0] yaw_rate;
    logic        [19:0] elapsed_time;
  } poi_in_t;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic        [31:0] heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               pose_enabled;
    logic               odom_enabled;
  } poi_out_t;

  typedef enum logic [3:0] {
    StIdle, StCordic1, StMulA, StMulB, StMulC, StRound1, StMulT1, StMulT2,
    StHead1, StHead2, StHead3, StCordic2, StDone
  } poi_state_e;

  // Serial multiplier request and status between sequencer and multiplier.
  typedef struct packed {
    logic start;
  } poi_mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } poi_mul_sts_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;       5'd21: r = 32'd326;
      5'd22: r = 32'd163;       5'd23: r = 32'd81;
      5'd24: r = 32'd41;        5'd25: r = 32'd20;
      5'd26: r = 32'd10;        5'd27: r = 32'd5;
      5'd28: r = 32'd3;         5'd29: r = 32'd1;
      5'd30: r = 32'd1;         default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/planar_odometry_integrator_unit.sv
// Top level of the planar odometry integrator: sequencer, CORDIC, serial multiplier, registers.
//
// One word runs from acceptance to result through two CORDIC runs and eight passes through the
// shared two-bit-a-cycle multiplier, each pass a start, the digit steps and a finish. The next
// word is taken only after the result has moved into the output register, and a result waiting
// downstream holds the unit in its done state, so it also holds up the following word.
module planar_odometry_integrator_unit import poi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  poi_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output poi_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  poi_state_e state_q, state_d;
  poi_in_t in_q;
  logic signed [31:0] east_q, east_d, north_q, north_d;
  logic [31:0] head_q, head_d;
  logic pose_en_q, odom_en_q;
  logic signed [63:0] acc_q, acc_d;   // partial sum of the rotated term
  logic signed [63:0] rx_q, rx_d, ry_q, ry_d;
  logic signed [33:0] c_q, c_d, s_q, s_d;
  logic [1:0] pass_q, pass_d;         // selects x or y, and the term within a sum
  logic neg_q, neg_d;
  logic [63:0] hp_q, hp_d;
  logic out_valid_q, out_valid_d;
  poi_out_t out_q, out_d;

  logic cor_start, cor_done;
  logic [31:0] cor_angle;
  logic signed [33:0] cor_c, cor_s;
  poi_mul_ctl_t mul_ctl;
  poi_mul_sts_t mul_sts;
  logic signed [63:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [95:0] mul_p;

  logic wr_en;
  logic signed [63:0] rnd14, rnd36;
  logic signed [32:0] sum_sat;
  logic [63:0] hmag;
  logic [31:0] hinc;
  logic signed [33:0] q_sin, q_cos;
  logic signed [33:0] zq, wq;
  logic signed [15:0] zq_sat, wq_sat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      RegPoseEn: prdata = {31'd0, pose_en_q};
      RegOdomEn: prdata = {31'd0, odom_en_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_en_q <= 1'b0;
      odom_en_q <= 1'b0;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegPoseEn) pose_en_q <= pwdata[0];
      else odom_en_q <= pwdata[0];
    end
  end

  poi_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cor_start), .angle_i(cor_angle),
    .done_o(cor_done), .cos_o(cor_c), .sin_o(cor_s)
  );

  poi_mul u_mul (
    .clk_i, .rst_ni, .ctl_i(mul_ctl), .a_i(mul_a), .b_i(mul_b),
    .sts_o(mul_sts), .p_o(mul_p)
  );

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    // Round half up at bit 14 and bit 36 of the running product.
    rnd14 = 64'((mul_p + 96'(acc_q) + 96'sd8192) >>> 14);
    rnd36 = 64'((mul_p + 96'sh8_0000_0000) >>> 36);
    hmag  = 64'((mul_p + 96'sh8_0000_0000) >>> 36);
    hinc  = neg_q ? (32'd0 - hmag[31:0]) : hmag[31:0];
    // A result held back waits with its sine and cosine in the local registers.
    q_sin = (state_q == StDone) ? s_q : cor_s;
    q_cos = (state_q == StDone) ? c_q : cor_c;
    zq    = (q_sin + 34'sd16384) >>> 15;
    wq    = (q_cos + 34'sd16384) >>> 15;
    if (zq > 34'sd32767) zq_sat = 16'sh7FFF;
    else if (zq < -34'sd32768) zq_sat = 16'sh8000;
    else zq_sat = zq[15:0];
    if (wq > 34'sd32767) wq_sat = 16'sh7FFF;
    else if (wq < -34'sd32768) wq_sat = 16'sh8000;
    else wq_sat = wq[15:0];
  end

  always_comb begin
    state_d = state_q; east_d = east_q; north_d = north_q; head_d = head_q;
    acc_d = acc_q; rx_d = rx_q; ry_d = ry_q; c_d = c_q; s_d = s_q;
    pass_d = pass_q; neg_d = neg_q; hp_d = hp_q;
    out_valid_d = out_valid_q; out_d = out_q;
    cor_start = 1'b0; cor_angle = head_q;
    mul_ctl.start = 1'b0; mul_a = '0; mul_b = '0;
    sum_sat = '0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    // Operand choice: x uses c and -s, y uses s and c.
    case (pass_q)
      2'd0: begin mul_a = 64'(c_q); mul_b = 32'(in_q.forward_speed); end
      2'd1: begin mul_a = -64'(s_q); mul_b = 32'(in_q.lateral_speed); end
      2'd2: begin mul_a = 64'(s_q); mul_b = 32'(in_q.forward_speed); end
      default: begin mul_a = 64'(c_q); mul_b = 32'(in_q.lateral_speed); end
    endcase

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cor_start = 1'b1;
          state_d = StCordic1;
        end
      end
      StCordic1: begin
        if (cor_done) begin
          c_d = cor_c;
          s_d = cor_s;
          pass_d = 2'd0;
          acc_d = '0;
          state_d = StMulA;
        end
      end
      StMulA: begin
        mul_ctl.start = 1'b1;
        state_d = StMulB;
      end
      StMulB: begin
        if (mul_sts.done) begin
          if (!pass_q[0]) begin
            acc_d = 64'(mul_p);
            pass_d = pass_q + 2'd1;
            state_d = StMulA;
          end else begin
            if (!pass_q[1]) rx_d = rnd14; else ry_d = rnd14;
            acc_d = '0;
            pass_d = pass_q + 2'd1;
            state_d = pass_q[1] ? StMulT1 : StMulA;
          end
        end
      end
      StMulT1: begin
        mul_ctl.start = 1'b1;
        mul_a = pass_q[0] ? ry_q : rx_q;
        mul_b = 32'({12'd0, in_q.elapsed_time});
        state_d = StMulT2;
      end
      StMulT2: begin
        if (mul_sts.done) begin
          if (!pass_q[0]) begin
            sum_sat = 33'(east_q) + 33'(rnd36);
            if (rnd36 > 64'sd4294967295) east_d = 32'sh7FFF_FFFF;
            else if (rnd36 < -64'sd4294967296) east_d = 32'sh8000_0000;
            else if (sum_sat > 33'sh0_7FFF_FFFF) east_d = 32'sh7FFF_FFFF;
            else if (sum_sat < -33'sh0_8000_0000) east_d = 32'sh8000_0000;
            else east_d = sum_sat[31:0];
            pass_d = 2'd1;
            state_d = StMulT1;
          end else begin
            sum_sat = 33'(north_q) + 33'(rnd36);
            if (rnd36 > 64'sd4294967295) north_d = 32'sh7FFF_FFFF;
            else if (rnd36 < -64'sd4294967296) north_d = 32'sh8000_0000;
            else if (sum_sat > 33'sh0_7FFF_FFFF) north_d = 32'sh7FFF_FFFF;
            else if (sum_sat < -33'sh0_8000_0000) north_d = 32'sh8000_0000;
            else north_d = sum_sat[31:0];
            state_d = StHead1;
          end
        end
      end
      StHead1: begin
        mul_ctl.start = 1'b1;
        mul_a = 64'(in_q.yaw_rate);
        mul_b = 32'({12'd0, in_q.elapsed_time});
        state_d = StHead2;
      end
      StHead2: begin
        if (mul_sts.done) begin
          neg_d = mul_p[95];
          hp_d = mul_p[95] ? 64'(-mul_p) : 64'(mul_p);
          state_d = StHead3;
        end
      end
      StHead3: begin
        // Magnitude times turns per radian, rounded half up at bit 36.
        if (!mul_sts.busy && !mul_sts.done && pass_q != 2'd3) begin
          mul_ctl.start = 1'b1;
          pass_d = 2'd3;
        end
        mul_a = signed'(hp_q);
        mul_b = 32'({2'b00, TurnPerRad});
        if (mul_sts.done) begin
          head_d = head_q + hinc;
          cor_start = 1'b1;
          cor_angle = {1'b0, head_d[31:1]};
          state_d = StCordic2;
        end
      end
      StCordic2: begin
        cor_angle = {1'b0, head_q[31:1]};
        if (cor_done && !out_valid_d) begin
          out_d.position_x = east_q;
          out_d.position_y = north_q;
          out_d.heading = head_q;
          out_d.quat_z = zq_sat;
          out_d.quat_w = wq_sat;
          out_d.pose_enabled = pose_en_q;
          out_d.odom_enabled = odom_en_q;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end else if (cor_done) begin
          state_d = StDone;
          c_d = cor_c;
          s_d = cor_s;
        end
      end
      StDone: begin
        if (!out_valid_d) begin
          out_d.position_x = east_q;
          out_d.position_y = north_q;
          out_d.heading = head_q;
          out_d.quat_z = zq_sat;
          out_d.quat_w = wq_sat;
          out_d.pose_enabled = pose_en_q;
          out_d.odom_enabled = odom_en_q;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      east_q      <= '0;
      north_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
      pass_q      <= '0;
    end else begin
      state_q     <= state_d;
      east_q      <= east_d;
      north_q     <= north_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
      pass_q      <= (state_q == StIdle) ? 2'd0 : pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    acc_q <= acc_d;
    rx_q  <= rx_d;
    ry_q  <= ry_d;
    c_q   <= c_d;
    s_q   <= s_d;
    neg_q <= neg_d;
    hp_q  <= hp_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("word taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_data_o)) else $error("result changed");
  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !mul_sts.done) else $error("multiplier done while idle");
`endif

endmodule

FILE: hdl/poi_cordic.sv
// Iterative CORDIC unit: cosine and sine of a binary angle, Q1.30, one step per cycle.
module poi_cordic import poi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic        [31:0] angle_i,
  output logic               done_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [33:0] z_q, z_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, flip_q, flip_d, done_q, done_d;
  logic [31:0] folded;
  logic [1:0] quad;

  assign quad = angle_i[31:30];

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; cnt_d = cnt_q;
    busy_d = busy_q; flip_d = flip_q; done_d = 1'b0;
    folded = angle_i;
    if (start_i) begin
      flip_d = (quad == 2'd1) || (quad == 2'd2);
      if (flip_d) folded = angle_i + 32'h8000_0000;
      x_d = 34'(signed'({1'b0, CordicGain}));
      y_d = '0;
      z_d = 34'(signed'(folded));
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == StepW'(CordicIters)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (flip_q) begin
          x_d = -x_q;
          y_d = -y_q;
        end
      end else begin
        // Arithmetic shift gives the floor of the scaled value.
        if (!z_q[33]) begin
          x_d = x_q - (y_q >>> cnt_q);
          y_d = y_q + (x_q >>> cnt_q);
          z_d = z_q - 34'(atan_lut(5'(cnt_q)));
        end else begin
          x_d = x_q + (y_q >>> cnt_q);
          y_d = y_q - (x_q >>> cnt_q);
          z_d = z_q + 34'(atan_lut(5'(cnt_q)));
        end
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      flip_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      flip_q <= flip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign cos_o  = x_q;
  assign sin_o  = y_q;

endmodule

FILE: hdl/poi_mul.sv
// Bit-serial signed multiplier: 64-bit multiplicand times 32-bit multiplier, two bits a cycle.
module poi_mul import poi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  poi_mul_ctl_t       ctl_i,
  input  logic signed [63:0] a_i,
  input  logic signed [31:0] b_i,
  output poi_mul_sts_t       sts_o,
  output logic signed [95:0] p_o
);

  logic signed [95:0] acc_q, acc_d;
  logic signed [95:0] mcand_q, mcand_d;
  logic [31:0] mplier_q, mplier_d;
  logic [4:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic signed [95:0] pp0, pp1;

  always_comb begin
    acc_d = acc_q; mcand_d = mcand_q; mplier_d = mplier_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    pp0 = mplier_q[0] ? mcand_q : '0;
    pp1 = mplier_q[1] ? (mcand_q <<< 1) : '0;
    if (ctl_i.start) begin
      acc_d = '0;
      mcand_d = 96'(a_i);
      mplier_d = b_i;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The top multiplier bit carries negative weight.
      if (cnt_q == 5'd15) begin
        if (mplier_q[1]) pp1 = -(mcand_q <<< 1);
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      acc_d = acc_q + pp0 + pp1;
      mcand_d = mcand_q <<< 2;
      mplier_d = mplier_q >> 2;
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign p_o = acc_q;

endmodule
